// ===== hw/rtl/vrt_pkg.sv =====
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the bounded voxel ray walker
// Fixed-point format, register indexes, result codes, setup op sequence and
// the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int INT_BITS  = 10;
  localparam int FRAC_BITS = 12;
  localparam int CW        = INT_BITS + FRAC_BITS;   // coordinate width
  localparam int VOX_W     = INT_BITS;               // voxel index width
  localparam int REG_W     = 11;                     // bound register width
  localparam int AD_W      = INT_BITS + 1;           // |voxel difference|
  localparam int NUM_W     = FRAC_BITS + 1;          // crossing numerator
  localparam int DIFF_W    = CW + 1;                 // end - start
  localparam int DLT_W     = CW + 2;                 // corner - start
  localparam int LAB_W     = NUM_W + INT_BITS + 1 + AD_W; // tMax cross products
  localparam int DIST_W    = 2 * DIFF_W + 2;         // squared distances
  localparam int MUL_W     = DIFF_W;                 // setup multiplier operand
  localparam int IDX_W     = 3;                      // config index width

  localparam int DEF_MAX_VOXELS = 63;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

  localparam logic [REG_W-1:0] MIN_RST = 11'h600;
  localparam logic [REG_W-1:0] MAX_RST = 11'h200;

  // final status codes
  localparam logic [1:0] ST_END  = 2'd0;
  localparam logic [1:0] ST_DIST = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_SAME = 2'd3;

  // setup op sequence: squared ray length, squared start offset, pair products
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_LEN_FIRST  = 4'd0;
  localparam logic [OP_W-1:0] OP_ORG_FIRST  = 4'd3;
  localparam logic [OP_W-1:0] OP_PAIR_FIRST = 4'd6;
  localparam logic [OP_W-1:0] OP_LAST       = 4'd11;

  // ordered axis pairs (a,b): cross product numerator(a) * |d(b)|
  localparam int NPAIR = 6;
  localparam logic [1:0] PAIR_A [NPAIR] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [NPAIR] = '{2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1};
  localparam int P01 = 0;
  localparam int P10 = 1;
  localparam int P02 = 2;
  localparam int P20 = 3;
  localparam int P12 = 4;
  localparam int P21 = 5;

  typedef struct packed {
    logic            load;    // capture a new ray
    logic            setup;   // run one setup op
    logic [OP_W-1:0] op;
    logic            walk;    // one voxel step
    logic            finish;  // emit final item
  } vrt_cmd_t;

  typedef struct packed {
    logic same_vox;
    logic walk_stop;
  } vrt_sts_t;

endpackage

// ===== hw/rtl/vrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrt_ctrl: ray walk sequencer
// Idle, setup op sequence, voxel walk and final item, one state each.
// ----------------------------------------------------------------------------
module vrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  vrt_pkg::vrt_sts_t sts_i,
  output vrt_pkg::vrt_cmd_t cmd_o,
  output logic              busy_o
);
  import vrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_FINISH
  } state_e;

  state_e          state_q;
  logic [OP_W-1:0] op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_LEN_FIRST;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          op_q <= OP_LEN_FIRST;
          if (start_i) state_q <= S_SETUP;
        end
        S_SETUP: begin
          // op holds at the last setup op through the walk
          if (op_q == OP_LAST) state_q <= sts_i.same_vox ? S_FINISH : S_WALK;
          else op_q <= op_q + 1'b1;
        end
        S_WALK: begin
          if (sts_i.walk_stop) state_q <= S_FINISH;
        end
        S_FINISH: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.setup  = (state_q == S_SETUP);
    cmd_o.op     = op_q;
    cmd_o.walk   = (state_q == S_WALK);
    cmd_o.finish = (state_q == S_FINISH);
  end

  a_walk_after_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && $past(state_q) != S_WALK) |-> $past(op_q) == OP_LAST)
    else $error("walk entered before setup finished");

  a_finish_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |=> state_q == S_IDLE)
    else $error("final item state held");

endmodule

// ===== hw/rtl/vrt_datapath.sv =====
// ----------------------------------------------------------------------------
// vrt_datapath: ray registers, setup multiplier and incremental DDA stepper
// Holds bounds, per-axis walk state, cross products, squared distances and
// the one-deep pending item that lets the last voxel be tagged.
// ----------------------------------------------------------------------------
module vrt_datapath #(
  parameter int MAX_VOXELS = vrt_pkg::DEF_MAX_VOXELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vrt_pkg::vrt_cmd_t                   cmd_i,
  output vrt_pkg::vrt_sts_t                   sts_o,
  input  logic                                cfg_we_i,
  input  logic [vrt_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [vrt_pkg::REG_W-1:0]           cfg_wdata_i,
  input  logic signed [vrt_pkg::CW-1:0]       start_x_i,
  input  logic signed [vrt_pkg::CW-1:0]       start_y_i,
  input  logic signed [vrt_pkg::CW-1:0]       start_z_i,
  input  logic signed [vrt_pkg::CW-1:0]       end_x_i,
  input  logic signed [vrt_pkg::CW-1:0]       end_y_i,
  input  logic signed [vrt_pkg::CW-1:0]       end_z_i,
  output logic                                res_valid_o,
  output logic signed [vrt_pkg::VOX_W-1:0]    vox_x_o,
  output logic signed [vrt_pkg::VOX_W-1:0]    vox_y_o,
  output logic signed [vrt_pkg::VOX_W-1:0]    vox_z_o,
  output logic                                has_voxel_o,
  output logic                                last_o,
  output logic [1:0]                          status_o
);
  import vrt_pkg::*;

  localparam int CNT_W = $clog2(MAX_VOXELS + 2);

  // bounds
  logic [REG_W-1:0] lo_q [3];
  logic [REG_W-1:0] hi_q [3];

  // per-axis ray state
  logic [VOX_W-1:0]  v_q   [3];
  logic [VOX_W-1:0]  ev_q  [3];
  logic [AD_W-1:0]   ad_q  [3];
  logic [NUM_W-1:0]  n_q   [3];
  logic [FRAC_BITS-1:0] f_q [3];
  logic [DIFF_W-1:0] mag_q [3];
  logic [DLT_W-1:0]  dlt_q [3];
  logic [2:0]        inf_q;
  logic [2:0]        neg_q;

  logic [LAB_W-1:0]  lab_q [NPAIR];
  logic [DIST_W-1:0] len_q, dist_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [1:0]        stat_q;

  logic             pend_vld_q;
  logic [VOX_W-1:0] pend_q [3];

  logic             res_valid_q, has_q, last_q;
  logic [1:0]       status_q;
  logic [VOX_W-1:0] out_q [3];

  // ray capture from ports
  logic [CW-1:0] s_in [3];
  logic [CW-1:0] e_in [3];
  assign s_in[0] = start_x_i;
  assign s_in[1] = start_y_i;
  assign s_in[2] = start_z_i;
  assign e_in[0] = end_x_i;
  assign e_in[1] = end_y_i;
  assign e_in[2] = end_z_i;

  logic [AD_W-1:0]   d_in   [3];
  logic [DIFF_W-1:0] dif_in [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_in[i]   = {e_in[i][CW-1], e_in[i][CW-1:FRAC_BITS]} -
                  {s_in[i][CW-1], s_in[i][CW-1:FRAC_BITS]};
      dif_in[i] = {e_in[i][CW-1], e_in[i]} - {s_in[i][CW-1], s_in[i]};
    end
  end

  // setup multiplier operand select
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [OP_W-1:0]    rel;
  logic [2:0]         pidx;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    rel   = '0;
    pidx  = '0;
    if (cmd_i.op >= OP_PAIR_FIRST) begin
      rel   = cmd_i.op - OP_PAIR_FIRST;
      pidx  = rel[2:0];
      mul_a = MUL_W'(n_q[PAIR_A[pidx]]);
      mul_b = MUL_W'(ad_q[PAIR_B[pidx]]);
    end else if (cmd_i.op >= OP_ORG_FIRST) begin
      rel   = cmd_i.op - OP_ORG_FIRST;
      mul_a = MUL_W'(f_q[rel[1:0]]);
      mul_b = MUL_W'(f_q[rel[1:0]]);
    end else begin
      rel   = cmd_i.op - OP_LEN_FIRST;
      mul_a = mag_q[rel[1:0]];
      mul_b = mag_q[rel[1:0]];
    end
  end
  assign prod = mul_a * mul_b;

  // axis choice by exact cross-multiplied compare
  function automatic logic ax_less(input logic ia, input logic ib,
                                   input logic [LAB_W-1:0] la,
                                   input logic [LAB_W-1:0] lb);
    logic r;
    if (ia)      r = 1'b0;
    else if (ib) r = 1'b1;
    else         r = (la < lb);
    return r;
  endfunction

  logic       lt01, lt02, lt12;
  logic [1:0] sel;
  assign lt01 = ax_less(inf_q[0], inf_q[1], lab_q[P01], lab_q[P10]);
  assign lt02 = ax_less(inf_q[0], inf_q[2], lab_q[P02], lab_q[P20]);
  assign lt12 = ax_less(inf_q[1], inf_q[2], lab_q[P12], lab_q[P21]);
  assign sel  = lt01 ? (lt02 ? 2'd0 : 2'd2) : (lt12 ? 2'd1 : 2'd2);

  // per-cycle walk checks
  logic inbox, at_end, dist_over, cnt_over, stop;
  always_comb begin
    inbox  = 1'b1;
    at_end = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!($signed({v_q[i][VOX_W-1], v_q[i]}) >= $signed(lo_q[i]) &&
            $signed({v_q[i][VOX_W-1], v_q[i]}) <  $signed(hi_q[i]))) inbox = 1'b0;
      if (v_q[i] != ev_q[i]) at_end = 1'b0;
    end
  end
  assign dist_over = dist_q > len_q;
  assign cnt_over  = (cnt_q == CNT_W'(MAX_VOXELS));
  assign stop      = (inbox && (dist_over || cnt_over)) || at_end;

  // squared distance update for one step on the chosen axis
  logic [DIST_W-1:0] dterm, dist_step;
  assign dterm     = DIST_W'($signed({dlt_q[sel], {(FRAC_BITS+1){1'b0}}}));
  assign dist_step = (neg_q[sel] ? dist_q - dterm : dist_q + dterm) +
                     (DIST_W'(1) << (2 * FRAC_BITS));

  assign sts_o.same_vox  = &inf_q;
  assign sts_o.walk_stop = cmd_i.walk && stop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= MIN_RST;
        hi_q[i] <= MAX_RST;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_X: lo_q[0] <= cfg_wdata_i;
        REG_MIN_Y: lo_q[1] <= cfg_wdata_i;
        REG_MIN_Z: lo_q[2] <= cfg_wdata_i;
        REG_MAX_X: hi_q[0] <= cfg_wdata_i;
        REG_MAX_Y: hi_q[1] <= cfg_wdata_i;
        REG_MAX_Z: hi_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      stat_q      <= ST_END;
    end else begin
      res_valid_q <= 1'b0;
      if (cmd_i.load) begin
        pend_vld_q <= 1'b0;
        cnt_q      <= '0;
        stat_q     <= ST_END;
      end
      if (cmd_i.walk) begin
        if (inbox) begin
          pend_vld_q <= 1'b1;
          cnt_q      <= cnt_q + 1'b1;
          if (pend_vld_q) res_valid_q <= 1'b1;
        end
        if (inbox && dist_over)     stat_q <= ST_DIST;
        else if (inbox && cnt_over) stat_q <= ST_OVF;
        else                        stat_q <= ST_END;
      end
      if (cmd_i.finish) res_valid_q <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i]   <= s_in[i][CW-1:FRAC_BITS];
        ev_q[i]  <= e_in[i][CW-1:FRAC_BITS];
        f_q[i]   <= s_in[i][FRAC_BITS-1:0];
        ad_q[i]  <= d_in[i][AD_W-1] ? AD_W'(0) - d_in[i] : d_in[i];
        inf_q[i] <= (d_in[i] == '0);
        neg_q[i] <= d_in[i][AD_W-1];
        mag_q[i] <= dif_in[i][DIFF_W-1] ? DIFF_W'(0) - dif_in[i] : dif_in[i];
        dlt_q[i] <= DLT_W'(0) - DLT_W'(s_in[i][FRAC_BITS-1:0]);
        if (!d_in[i][AD_W-1])
          n_q[i] <= (NUM_W'(1) << FRAC_BITS) - NUM_W'(s_in[i][FRAC_BITS-1:0]);
        else if (s_in[i][FRAC_BITS-1:0] != '0)
          n_q[i] <= NUM_W'(s_in[i][FRAC_BITS-1:0]);
        else
          n_q[i] <= NUM_W'(1) << FRAC_BITS;
      end
      len_q  <= '0;
      dist_q <= '0;
    end
    if (cmd_i.setup) begin
      if (cmd_i.op >= OP_PAIR_FIRST)      lab_q[pidx] <= LAB_W'(prod);
      else if (cmd_i.op >= OP_ORG_FIRST)  dist_q <= dist_q + DIST_W'(prod);
      else                                len_q  <= len_q + DIST_W'(prod);
    end
    if (cmd_i.walk) begin
      if (inbox) begin
        for (int i = 0; i < 3; i++) begin
          pend_q[i] <= v_q[i];
          out_q[i]  <= pend_q[i];
        end
        has_q    <= 1'b1;
        last_q   <= 1'b0;
        status_q <= ST_END;
      end
      if (!stop) begin
        v_q[sel]   <= neg_q[sel] ? v_q[sel] - 1'b1 : v_q[sel] + 1'b1;
        dlt_q[sel] <= neg_q[sel] ? dlt_q[sel] - (DLT_W'(1) << FRAC_BITS)
                                 : dlt_q[sel] + (DLT_W'(1) << FRAC_BITS);
        dist_q     <= dist_step;
        for (int p = 0; p < NPAIR; p++) begin
          if (PAIR_A[p] == sel)
            lab_q[p] <= lab_q[p] + (LAB_W'(ad_q[PAIR_B[p]]) << FRAC_BITS);
        end
      end
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < 3; i++) out_q[i] <= pend_vld_q ? pend_q[i] : '0;
      has_q    <= pend_vld_q;
      last_q   <= 1'b1;
      status_q <= (&inf_q) ? ST_SAME : stat_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign vox_x_o     = out_q[0];
  assign vox_y_o     = out_q[1];
  assign vox_z_o     = out_q[2];
  assign has_voxel_o = has_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |=> !res_valid_o)
    else $error("result after last item");

  a_mid_has_voxel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> (has_voxel_o && status_o == ST_END))
    else $error("non-final item without voxel");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> cnt_q <= CNT_W'(MAX_VOXELS))
    else $error("voxel count past limit while walking");

endmodule

// ===== hw/rtl/voxel_ray_traversal_bounded_core.sv =====
// ----------------------------------------------------------------------------
// voxel_ray_traversal_bounded_core: bounded 3-D voxel ray walk
// Sequence: accept, 12 setup ops, then one voxel visited per cycle
//   (|dx|+|dy|+|dz|+1 voxels at most), then the final item.
// Throughput: one ray at a time; busy_o stays high until the last result.
// Setup time is set by a single shared 23x23 multiplier run over 12 ops.
// Results are strobed by res_valid_o for one cycle each; no back-pressure.
// Reset (rst_ni low, async) idles the sequencer and restores the bounds.
// ----------------------------------------------------------------------------
//
// A ray is taken as start/end points in signed Q10.12. The walk goes from
// floor(start) to floor(end), choosing the axis whose next boundary crossing
// is nearest. Crossing times tMax = (num + k)/|d| are held as exact cross
// products num_a*|d_b|, so each choice is three plain compares and a step is
// a shifted add. The squared distance of the current voxel corner to start
// is also updated by adds only, and compared against the squared ray length.
//
// Voxels inside [min, max) are emitted. Each emitted voxel waits in a
// one-deep pending register until the next one arrives or the walk ends, so
// the final voxel can carry last=1 and the final status. A ray that emits
// nothing ends with a single empty item.
module voxel_ray_traversal_bounded_core #(
  parameter int MAX_VOXELS = vrt_pkg::DEF_MAX_VOXELS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command transaction
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [vrt_pkg::CW-1:0]    start_x_i,
  input  logic signed [vrt_pkg::CW-1:0]    start_y_i,
  input  logic signed [vrt_pkg::CW-1:0]    start_z_i,
  input  logic signed [vrt_pkg::CW-1:0]    end_x_i,
  input  logic signed [vrt_pkg::CW-1:0]    end_y_i,
  input  logic signed [vrt_pkg::CW-1:0]    end_z_i,
  // bound registers
  input  logic                             cfg_we_i,
  input  logic [vrt_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [vrt_pkg::REG_W-1:0]        cfg_wdata_i,
  // result transactions
  output logic                             res_valid_o,
  output logic signed [vrt_pkg::VOX_W-1:0] vox_x_o,
  output logic signed [vrt_pkg::VOX_W-1:0] vox_y_o,
  output logic signed [vrt_pkg::VOX_W-1:0] vox_z_o,
  output logic                             has_voxel_o,
  output logic                             last_o,
  output logic [1:0]                       status_o
);
  import vrt_pkg::*;

  vrt_cmd_t cmd;
  vrt_sts_t sts;
  logic     busy;

  // sequencer: idle -> setup ops -> walk -> final item
  vrt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // arithmetic, walk state and result registers
  vrt_datapath #(
    .MAX_VOXELS (MAX_VOXELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .start_z_i   (start_z_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .end_z_i     (end_z_i),
    .res_valid_o (res_valid_o),
    .vox_x_o     (vox_x_o),
    .vox_y_o     (vox_y_o),
    .vox_z_o     (vox_z_o),
    .has_voxel_o (has_voxel_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  assign busy_o = busy;

  // a new command is only taken while no result of the previous one is due
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !res_valid_o)
    else $error("result strobed right after accept");

  // the core is already idle while the last item of a ray is strobed
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |-> !busy_o)
    else $error("still busy after final item");

  a_same_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o == ST_SAME) |-> (last_o && !has_voxel_o))
    else $error("same-voxel ray emitted a voxel");

endmodule

// ===== dv/tb_voxel_ray_traversal_bounded_core.sv =====
// ----------------------------------------------------------------------------
// tb_voxel_ray_traversal_bounded_core: self-checking bench of the voxel walker
// Directed rays from a table, then random rays under several bound settings.
// Every result transaction is compared field by field with a local DDA walk.
// ----------------------------------------------------------------------------
module tb_voxel_ray_traversal_bounded_core;
  import vrt_pkg::*;

  localparam int MAXV      = DEF_MAX_VOXELS;
  localparam int STOP_LIM  = 20000;  // idle cycles before the watchdog fires
  localparam longint ONE_Q = 64'sd1 << FRAC_BITS;

  typedef struct packed {
    logic signed [VOX_W-1:0] vx;
    logic signed [VOX_W-1:0] vy;
    logic signed [VOX_W-1:0] vz;
    logic                    has;
    logic                    lst;
    logic [1:0]              st;
  } voxel_item_t;

  typedef struct {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
  } ray_t;

  // one directed row; chk_st asks for a typed-in status on the final item
  typedef struct {
    ray_t       r;
    logic       chk_st;
    logic [1:0] st;
  } ray_row_t;

  logic clk_i, rst_ni, start_i, busy_o, cfg_we_i;
  logic signed [CW-1:0] start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0] cfg_wdata_i;
  logic res_valid_o, has_voxel_o, last_o;
  logic signed [VOX_W-1:0] vox_x_o, vox_y_o, vox_z_o;
  logic [1:0] status_o;

  voxel_ray_traversal_bounded_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  logic [REG_W-1:0] bound_q [6];
  voxel_item_t voxel_q [$];
  int n_err = 0;
  int quiet_cnt = 0;
  logic no_idle = 1'b0;

  task automatic report_mismatch(input string what, input voxel_item_t got,
                                 input voxel_item_t want);
    $display("mismatch %s: got %0d %0d %0d h%0b l%0b s%0d want %0d %0d %0d h%0b l%0b s%0d",
             what, got.vx, got.vy, got.vz, got.has, got.lst, got.st,
             want.vx, want.vy, want.vz, want.has, want.lst, want.st);
    n_err++;
  endtask

  // append one expected item at the tail of the queue
  function automatic void enqueue_item(input voxel_item_t it);
    voxel_q.insert(voxel_q.size(), it);
  endfunction

  function automatic longint vfloor(longint v);
    return (v - (v & (ONE_Q - 1))) / ONE_Q;
  endfunction

  // crossing compare a < b, exact by cross-multiplication; infinite never less
  function automatic bit cross_lt(bit ia, longint na, longint ka, longint da,
                                  bit ib, longint nb, longint kb, longint db);
    if (ia) return 1'b0;
    if (ib) return 1'b1;
    return (na + ka * ONE_Q) * db < (nb + kb * ONE_Q) * da;
  endfunction

  // walk one ray and queue the voxels it should produce
  task automatic walk_ray(input ray_t r);
    longint s[3], e[3], v[3], ev[3], n[3], k[3], ad[3], stp[3], lo[3], hi[3];
    bit inf[3];
    logic signed [127:0] len2, d2;
    voxel_item_t it;
    int cnt, a;
    logic [1:0] st;
    s = '{r.sx, r.sy, r.sz};
    e = '{r.ex, r.ey, r.ez};
    len2 = 0; cnt = 0; st = ST_END;
    for (int i = 0; i < 3; i++) begin
      longint d, f;
      v[i] = vfloor(s[i]); ev[i] = vfloor(e[i]);
      d = ev[i] - v[i];
      f = s[i] & (ONE_Q - 1);
      k[i] = 0; inf[i] = (d == 0);
      stp[i] = d > 0 ? 1 : (d < 0 ? -1 : 0);
      ad[i] = d < 0 ? -d : d;
      n[i] = d > 0 ? ONE_Q - f : (f != 0 ? f : ONE_Q);
      len2 += 128'(e[i] - s[i]) * 128'(e[i] - s[i]);
      lo[i] = longint'($signed(bound_q[i]));
      hi[i] = longint'($signed(bound_q[3+i]));
    end
    if (inf[0] && inf[1] && inf[2]) st = ST_SAME;
    else begin
      for (int step = 0; step < 3 * 1024 + 8; step++) begin
        if (v[0] >= lo[0] && v[0] < hi[0] && v[1] >= lo[1] && v[1] < hi[1] &&
            v[2] >= lo[2] && v[2] < hi[2]) begin
          d2 = 0;
          for (int i = 0; i < 3; i++)
            d2 += 128'(v[i] * ONE_Q - s[i]) * 128'(v[i] * ONE_Q - s[i]);
          it = '{vx: v[0][VOX_W-1:0], vy: v[1][VOX_W-1:0], vz: v[2][VOX_W-1:0],
                 has: 1'b1, lst: 1'b0, st: ST_END};
          enqueue_item(it);
          cnt++;
          if (d2 > len2) begin st = ST_DIST; break; end
          if (cnt > MAXV) begin st = ST_OVF; break; end
        end
        if (v[0] == ev[0] && v[1] == ev[1] && v[2] == ev[2]) begin
          st = ST_END; break;
        end
        if (cross_lt(inf[0], n[0], k[0], ad[0], inf[1], n[1], k[1], ad[1]))
          a = cross_lt(inf[0], n[0], k[0], ad[0], inf[2], n[2], k[2], ad[2]) ? 0 : 2;
        else
          a = cross_lt(inf[1], n[1], k[1], ad[1], inf[2], n[2], k[2], ad[2]) ? 1 : 2;
        v[a] += stp[a];
        k[a]++;
      end
    end
    if (cnt == 0) enqueue_item('{default: '0});
    voxel_q[$].lst = 1'b1;
    voxel_q[$].st  = st;
  endtask

  // result monitor: sampled at the edge that ends the strobe cycle
  always @(posedge clk_i) begin
    voxel_item_t got;
    if (res_valid_o) begin
      got = '{vox_x_o, vox_y_o, vox_z_o, has_voxel_o, last_o, status_o};
      if (voxel_q.size() == 0) report_mismatch("unexpected", got, '{default: '0});
      else if (got !== voxel_q[0]) report_mismatch("field", got, voxel_q.pop_front());
      else void'(voxel_q.pop_front());
    end
  end

  // watchdog on cycles with no transaction in either direction
  always @(posedge clk_i) begin
    if (res_valid_o || (start_i && !busy_o)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt > STOP_LIM) begin
      $display("tb_voxel_ray_traversal_bounded_core failed");
      $finish;
    end
  end

  task automatic write_bound(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    bound_q[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // let the current ray finish, then a margin for the tail of the walk
  task automatic drain();
    while (voxel_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_box(input int lx, ly, lz, hx, hy, hz);
    drain();
    write_bound(REG_MIN_X, lx[REG_W-1:0]); write_bound(REG_MIN_Y, ly[REG_W-1:0]);
    write_bound(REG_MIN_Z, lz[REG_W-1:0]); write_bound(REG_MAX_X, hx[REG_W-1:0]);
    write_bound(REG_MAX_Y, hy[REG_W-1:0]); write_bound(REG_MAX_Z, hz[REG_W-1:0]);
  endtask

  // present one ray from the edge after the previous accept, or later after random idle
  // edges unless no_idle is set; start stays high until the accept edge
  task automatic send_ray(input ray_t r);
    @(posedge clk_i);
    if (!no_idle)
      while ($urandom_range(99) < 18) @(posedge clk_i);
    start_i <= 1'b1;
    start_x_i <= r.sx; start_y_i <= r.sy; start_z_i <= r.sz;
    end_x_i <= r.ex; end_y_i <= r.ey; end_z_i <= r.ez;
    do @(posedge clk_i); while (busy_o);
    walk_ray(r);
    start_i <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] q(int vox, int frac);
    return CW'(vox * 4096 + frac);
  endfunction

  // random coordinate: mostly near an anchor, sometimes anywhere
  function automatic logic signed [CW-1:0] rnd_coord(int anchor, int span);
    if ($urandom_range(9) == 0) return CW'($urandom);
    return CW'((anchor + $urandom_range(2 * span) - span) * 4096 + $urandom_range(4095));
  endfunction

  function automatic ray_t rnd_ray(int span);
    ray_t r;
    int ax, ay, az;
    ax = $urandom_range(200) - 100; ay = $urandom_range(200) - 100;
    az = $urandom_range(200) - 100;
    r.sx = rnd_coord(ax, 3); r.sy = rnd_coord(ay, 3); r.sz = rnd_coord(az, 3);
    r.ex = rnd_coord(ax, span); r.ey = rnd_coord(ay, span); r.ez = rnd_coord(az, span);
    // some rays on axis-aligned paths, in a plane of constant x, or on same-voxel paths
    case ($urandom_range(7))
      0: begin r.ey = r.sy; r.ez = r.sz; end
      1: r.ex = r.sx;
      2: begin r.ex = r.sx; r.ey = r.sy; r.ez = r.sz; end
      default: ;
    endcase
    return r;
  endfunction

  ray_row_t dir_tab [$];
  localparam logic signed [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};

  initial begin
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0; start_i = 1'b0;
    {start_x_i, start_y_i, start_z_i, end_x_i, end_y_i, end_z_i} = '0;
    bound_q = '{MIN_RST, MIN_RST, MIN_RST, MAX_RST, MAX_RST, MAX_RST};
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rays; statuses typed in where obvious
    dir_tab = '{
      '{'{q(1,5), q(2,7), q(3,9), q(1,100), q(2,0), q(3,4095)}, 1, ST_SAME},
      '{'{q(0,0), q(0,0), q(0,0), q(5,0), q(0,0), q(0,0)}, 1, ST_END},
      '{'{q(0,0), q(0,0), q(0,0), q(-5,0), q(0,0), q(0,0)}, 1, ST_END},
      '{'{q(0,0), q(0,0), q(0,0), q(0,0), q(-6,0), q(0,0)}, 1, ST_END},
      '{'{q(0,0), q(0,0), q(0,0), q(0,0), q(0,0), q(7,0)}, 1, ST_END},
      '{'{q(0,0), q(0,0), q(0,0), q(100,0), q(0,0), q(0,0)}, 1, ST_OVF},
      '{'{q(0,2048), q(0,2048), q(0,2048), q(4,2048), q(4,2048), q(4,2048)}, 0, 0},
      '{'{q(0,0), q(0,0), q(0,0), q(3,0), q(3,0), q(0,0)}, 0, 0},
      '{'{q(0,0), q(0,0), q(0,0), q(3,0), q(0,0), q(3,0)}, 0, 0},
      '{'{q(0,4095), q(0,1), q(0,0), q(-3,1), q(4,4000), q(-2,0)}, 0, 0},
      '{'{q(0,3000), q(0,0), q(0,0), q(1,10), q(0,0), q(0,0)}, 0, 0},
      '{'{q(2,0), q(1,0), q(-1,0), q(-7,9), q(8,3), q(5,2)}, 0, 0},
      '{'{QMAX, QMAX, QMAX, QMIN, QMIN, QMIN}, 0, 0},
      '{'{QMIN, QMIN, QMIN, QMAX, QMIN, QMIN}, 0, 0},
      '{'{q(511,4095), q(-512,0), q(0,0), q(508,0), q(-509,0), q(2,0)}, 0, 0},
      '{'{q(600,0), q(600,0), q(600,0), q(605,0), q(601,0), q(600,0)}, 1, ST_END},
      '{'{q(0,4095), q(0,0), q(0,0), q(1,0), q(1,0), q(1,0)}, 0, 0}
    };
    foreach (dir_tab[i]) begin
      send_ray(dir_tab[i].r);
      if (dir_tab[i].chk_st && voxel_q[$].st !== dir_tab[i].st)
        report_mismatch("directed status", voxel_q[$], '{default: '0, st: dir_tab[i].st});
    end

    // one pause with everything drained before the next ray
    drain();

    // random rays over several boxes, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_box(-512, -512, -512, 512, 512, 512);
        1: set_box(-8, -8, -8, 8, 8, 8);
        2: set_box(-1024, -1024, -1024, 1023, 1023, 1023);
        3: set_box(3, -50, 0, 3, 50, 100);
        4: set_box(-100, -100, -100, 20, 20, 20);
      endcase
      no_idle = (ph == 2);
      for (int j = 0; j < 40; j++) send_ray(rnd_ray(ph == 3 ? 60 : 12));
    end

    drain();
    if (n_err == 0) $display("tb_voxel_ray_traversal_bounded_core passed");
    else $display("tb_voxel_ray_traversal_bounded_core failed");
    $finish;
  end

endmodule
